FILE: src/nmea_pkg.sv
// Shared constants, types and helper functions of the NMEA sentence parser.
package nmea_pkg;

   localparam int FIELDS      = 32;
   localparam int FIELD_CHARS = 16;
   localparam int STORE_DEPTH = FIELDS * FIELD_CHARS;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int FIELD_W     = $clog2(FIELDS);
   localparam int IDX_W       = $clog2(FIELDS + 1);
   localparam int CHAR_W      = $clog2(FIELD_CHARS);
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_STAR   = 8'h2A;

   typedef enum logic [3:0] {
      PH_HUNT = 4'b0001,
      PH_BODY = 4'b0010,
      PH_CHI  = 4'b0100,
      PH_CLO  = 4'b1000
   } phase_type;

   // One finished result waiting for the response channel.
   typedef struct packed {
      logic       sentence_ok;
      logic       format_error;
      logic       checksum_error;
      logic [5:0] field_count;
      logic [7:0] read_char;
   } result_type;

   // Access to the field store issued by the front end.
   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      logic [7:0]        wdata;
      logic              re;
      logic [ADDR_W-1:0] raddr;
   } store_req_type;

   // Letters count on from ten, anything that is not a digit or a letter counts nought.
   function automatic logic [5:0] hex_value(input logic [7:0] c);
      logic [5:0] v;
      v = '0;
      if (c >= 8'h30 && c <= 8'h39) begin
         v = 6'(c - 8'h30);
      end else if (c >= 8'h41 && c <= 8'h5A) begin
         v = 6'(c - 8'h41 + 8'd10);
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         v = 6'(c - 8'h61 + 8'd10);
      end
      return v;
   endfunction

   function automatic logic [ADDR_W-1:0] store_addr(input logic [FIELD_W-1:0] f,
                                                    input logic [CHAR_W-1:0] p);
      return ADDR_W'(int'(f) * FIELD_CHARS + int'(p));
   endfunction

endpackage

FILE: src/nmea_sentence_parser.sv
// Top level of the NMEA 0183 sentence parser: front end, field store and result queue.
//
// The parser takes one request per clock cycle while req_ready is high, and gives
// exactly one response per request, by way of the read stage register and the result
// queue. The sentence state machine settles each received byte as it is accepted; a
// field read goes through the registered read port of the 512-byte field store.
// Up to four responses are buffered, so requests keep flowing while the response
// side stalls, until the queue is full. After reset the field store is cleared at
// one byte a cycle, which keeps req_ready low until all 512 bytes are cleared.
module nmea_sentence_parser (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_mode,
   input  logic [7:0] req_rx_char,
   input  logic [4:0] req_read_field,
   input  logic [3:0] req_read_pos,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_sentence_ok,
   output logic       rsp_format_error,
   output logic       rsp_checksum_error,
   output logic [5:0] rsp_field_count,
   output logic [7:0] rsp_read_char
);
   import nmea_pkg::*;

   store_req_type     store_req;
   logic [7:0]        store_rdata;
   logic              push;
   result_type        push_data;
   result_type        rsp_data;
   logic [QCNT_W-1:0] q_count;

   nmea_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_rx_char    (req_rx_char),
      .req_read_field (req_read_field),
      .req_read_pos   (req_read_pos),
      .q_count        (q_count),
      .store_req      (store_req),
      .store_rdata    (store_rdata),
      .push           (push),
      .push_data      (push_data)
   );

   nmea_ram #(
      .WIDTH (8),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock (clock),
      .we    (store_req.we),
      .waddr (store_req.waddr),
      .wdata (store_req.wdata),
      .re    (store_req.re),
      .raddr (store_req.raddr),
      .rdata (store_rdata)
   );

   nmea_result_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .count     (q_count),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_sentence_ok    = rsp_data.sentence_ok;
   assign rsp_format_error   = rsp_data.format_error;
   assign rsp_checksum_error = rsp_data.checksum_error;
   assign rsp_field_count    = rsp_data.field_count;
   assign rsp_read_char      = rsp_data.read_char;

endmodule

FILE: src/nmea_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module nmea_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: src/nmea_front.sv
// Front end: accepts requests, runs the sentence state machine and drives the field store.
module nmea_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_mode,
   input  logic [7:0]              req_rx_char,
   input  logic [4:0]              req_read_field,
   input  logic [3:0]              req_read_pos,
   input  logic [nmea_pkg::QCNT_W-1:0] q_count,
   output nmea_pkg::store_req_type store_req,
   input  logic [7:0]              store_rdata,
   output logic                    push,
   output nmea_pkg::result_type    push_data
);
   import nmea_pkg::*;

   phase_type          phase_ff, phase_in;
   logic [7:0]         xor_ff, xor_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [CHAR_W-1:0]  cnt_ff, cnt_in;
   logic [9:0]         check_ff, check_in;
   logic               clear_ff, clear_in;
   logic [ADDR_W-1:0]  clr_addr_ff, clr_addr_in;

   logic               s1_valid_ff;
   logic               s1_ok_ff, s1_ferr_ff, s1_cerr_ff;
   logic [5:0]         s1_count_ff;
   logic               s1_rd_ff;
   logic               ok, ferr, cerr, rd_hit;
   logic               accept;
   logic [5:0]         hexv;
   store_req_type      sreq;

   // Room is reserved for the result still in the read stage.
   assign req_ready = !clear_ff &&
                      (int'(q_count) + int'(s1_valid_ff) < QUEUE_DEPTH);
   assign accept    = req_valid && req_ready;
   assign hexv      = hex_value(req_rx_char);

   always_comb begin
      phase_in    = phase_ff;
      xor_in      = xor_ff;
      idx_in      = idx_ff;
      cnt_in      = cnt_ff;
      check_in    = check_ff;
      clear_in    = clear_ff;
      clr_addr_in = clr_addr_ff;
      ok          = 1'b0;
      ferr        = 1'b0;
      cerr        = 1'b0;
      rd_hit      = 1'b0;
      sreq        = '0;

      if (clear_ff) begin
         sreq.we     = 1'b1;
         sreq.waddr  = clr_addr_ff;
         sreq.wdata  = '0;
         clr_addr_in = ADDR_W'(clr_addr_ff + 1'b1);
         if (int'(clr_addr_ff) == STORE_DEPTH - 1) begin
            clear_in = 1'b0;
         end
      end else if (accept && req_mode) begin
         if (int'(req_read_field) < FIELDS && int'(req_read_pos) < FIELD_CHARS) begin
            rd_hit     = 1'b1;
            sreq.re    = 1'b1;
            sreq.raddr = store_addr(FIELD_W'(req_read_field), CHAR_W'(req_read_pos));
         end
      end else if (accept) begin
         unique case (phase_ff)
            PH_HUNT: begin
               if (req_rx_char == CH_DOLLAR) begin
                  xor_in   = CH_STAR;
                  phase_in = PH_BODY;
                  idx_in   = '0;
                  cnt_in   = '0;
               end
            end
            PH_BODY: begin
               xor_in = xor_ff ^ req_rx_char;
               if (req_rx_char == CH_COMMA || req_rx_char == CH_STAR) begin
                  // A terminator for a field beyond the last slot is dropped.
                  if (int'(idx_ff) < FIELDS) begin
                     sreq.we    = 1'b1;
                     sreq.waddr = store_addr(FIELD_W'(idx_ff), cnt_ff);
                     sreq.wdata = '0;
                     idx_in     = IDX_W'(idx_ff + 1'b1);
                  end
                  if (req_rx_char == CH_COMMA) begin
                     cnt_in = '0;
                  end else begin
                     phase_in = PH_CHI;
                  end
               end else if (int'(idx_ff) < FIELDS && int'(cnt_ff) < FIELD_CHARS - 1) begin
                  sreq.we    = 1'b1;
                  sreq.waddr = store_addr(FIELD_W'(idx_ff), cnt_ff);
                  sreq.wdata = req_rx_char;
                  cnt_in     = CHAR_W'(cnt_ff + 1'b1);
               end else begin
                  ferr     = 1'b1;
                  phase_in = PH_HUNT;
               end
            end
            PH_CHI: begin
               check_in = {hexv, 4'b0000};
               phase_in = PH_CLO;
            end
            PH_CLO: begin
               if ({3'b000, xor_ff} == 11'(check_ff) + 11'(hexv)) begin
                  ok = 1'b1;
               end else begin
                  cerr = 1'b1;
               end
               phase_in = PH_HUNT;
            end
            default: begin
               phase_in = PH_HUNT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HUNT;
         xor_ff      <= '0;
         idx_ff      <= '0;
         cnt_ff      <= '0;
         check_ff    <= '0;
         clear_ff    <= 1'b1;
         clr_addr_ff <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         xor_ff      <= xor_in;
         idx_ff      <= idx_in;
         cnt_ff      <= cnt_in;
         check_ff    <= check_in;
         clear_ff    <= clear_in;
         clr_addr_ff <= clr_addr_in;
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      s1_ok_ff    <= ok;
      s1_ferr_ff  <= ferr;
      s1_cerr_ff  <= cerr;
      s1_count_ff <= 6'(idx_in);
      s1_rd_ff    <= rd_hit;
   end

   assign store_req = sreq;
   assign push      = s1_valid_ff;

   always_comb begin
      push_data.sentence_ok    = s1_ok_ff;
      push_data.format_error   = s1_ferr_ff;
      push_data.checksum_error = s1_cerr_ff;
      push_data.field_count    = s1_count_ff;
      push_data.read_char      = s1_rd_ff ? store_rdata : 8'h00;
   end

endmodule

FILE: src/nmea_result_queue.sv
// Back end: a short queue of finished results that drives the response channel.
module nmea_result_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  nmea_pkg::result_type        push_data,
   output logic [nmea_pkg::QCNT_W-1:0] count,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output nmea_pkg::result_type        rsp_data
);
   import nmea_pkg::*;

   result_type         entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               pop;

   assign rsp_valid = (count_ff != '0);
   assign pop       = rsp_valid && rsp_ready;
   assign rsp_data  = entry_ff[rd_ptr_ff];
   assign count     = count_ff;

   always_comb begin
      wr_ptr_in = push ? QPTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? QPTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = QCNT_W'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = QCNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: sim/nmea_sentence_checker.sv
// Checker for the NMEA sentence parser: tracks parser state and compares every response.
module nmea_sentence_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic       req_mode,
   input  logic [7:0] req_rx_char,
   input  logic [4:0] req_read_field,
   input  logic [3:0] req_read_pos,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic       rsp_sentence_ok,
   input  logic       rsp_format_error,
   input  logic       rsp_checksum_error,
   input  logic [5:0] rsp_field_count,
   input  logic [7:0] rsp_read_char,
   output int         failures,
   output int         outstanding,
   output int         good_count,
   output int         format_count,
   output int         checksum_count
);
   import nmea_pkg::*;

   logic [7:0]  field_bytes [STORE_DEPTH];
   phase_type   parse_phase;
   logic [7:0]  body_xor;
   int unsigned closed_fields;
   int unsigned open_chars;
   logic [9:0]  check_hi;
   result_type  awaited_results [$];
   int          fail_total;
   int          good_total;
   int          format_total;
   int          checksum_total;

   // Digits count nought to nine, letters of either case count on from ten.
   function automatic int unsigned digit_weight(input logic [7:0] c);
      int unsigned w;
      w = 0;
      if (c >= "0" && c <= "9") begin
         w = c - "0";
      end else if (c >= "A" && c <= "Z") begin
         w = c - "A" + 10;
      end else if (c >= "a" && c <= "z") begin
         w = c - "a" + 10;
      end
      return w;
   endfunction

   // A terminator for a field beyond the last slot is dropped.
   function automatic void close_open_field();
      if (closed_fields < FIELDS) begin
         field_bytes[closed_fields * FIELD_CHARS + open_chars] = 8'h00;
         closed_fields++;
      end
   endfunction

   function automatic result_type next_parser_result(input logic       mode,
                                                     input logic [7:0] c,
                                                     input logic [4:0] rf,
                                                     input logic [3:0] rp);
      result_type r;
      r = '0;
      if (mode) begin
         if (int'(rf) < FIELDS && int'(rp) < FIELD_CHARS) begin
            r.read_char = field_bytes[int'(rf) * FIELD_CHARS + int'(rp)];
         end
      end else begin
         case (parse_phase)
            PH_HUNT: begin
               if (c == CH_DOLLAR) begin
                  body_xor      = CH_STAR;
                  parse_phase   = PH_BODY;
                  closed_fields = 0;
                  open_chars    = 0;
               end
            end
            PH_BODY: begin
               body_xor = body_xor ^ c;
               if (c == CH_COMMA) begin
                  close_open_field();
                  open_chars = 0;
               end else if (c == CH_STAR) begin
                  close_open_field();
                  parse_phase = PH_CHI;
               end else if (closed_fields < FIELDS && open_chars < FIELD_CHARS - 1) begin
                  field_bytes[closed_fields * FIELD_CHARS + open_chars] = c;
                  open_chars++;
               end else begin
                  r.format_error = 1'b1;
                  parse_phase    = PH_HUNT;
               end
            end
            PH_CHI: begin
               check_hi    = 10'(digit_weight(c) * 16);
               parse_phase = PH_CLO;
            end
            default: begin
               if (int'(body_xor) == int'(check_hi) + int'(digit_weight(c))) begin
                  r.sentence_ok = 1'b1;
               end else begin
                  r.checksum_error = 1'b1;
               end
               parse_phase = PH_HUNT;
            end
         endcase
      end
      r.field_count = 6'(closed_fields);
      return r;
   endfunction

   always @(posedge clock) begin : watch_channels
      result_type want;
      if (reset) begin
         for (int i = 0; i < STORE_DEPTH; i++) begin
            field_bytes[i] = 8'h00;
         end
         parse_phase    = PH_HUNT;
         body_xor       = 8'h00;
         closed_fields  = 0;
         open_chars     = 0;
         check_hi       = 10'd0;
         fail_total     = 0;
         good_total     = 0;
         format_total   = 0;
         checksum_total = 0;
         awaited_results.delete();
      end else begin
         // The parser answers a request only through its read stage register and result queue, so the
         // response side is settled before this edge's request is queued.
         if (rsp_valid && rsp_ready) begin
            if (awaited_results.size() == 0) begin
               fail_total++;
               if (fail_total <= 10) begin
                  $display("[%0t] response with no request outstanding", $realtime);
               end
            end else begin
               want = awaited_results.pop_front();
               if (rsp_sentence_ok !== want.sentence_ok
                   || rsp_format_error !== want.format_error
                   || rsp_checksum_error !== want.checksum_error
                   || rsp_field_count !== want.field_count
                   || rsp_read_char !== want.read_char) begin
                  fail_total++;
                  if (fail_total <= 10) begin
                     $display("[%0t] expected ok=%0b fmt=%0b sum=%0b fields=%0d byte=%02h",
                              $realtime, want.sentence_ok, want.format_error,
                              want.checksum_error, want.field_count, want.read_char);
                     $display("[%0t]      got ok=%0b fmt=%0b sum=%0b fields=%0d byte=%02h",
                              $realtime, rsp_sentence_ok, rsp_format_error,
                              rsp_checksum_error, rsp_field_count, rsp_read_char);
                  end
               end
            end
         end
         if (req_valid && req_ready) begin
            want = next_parser_result(req_mode, req_rx_char, req_read_field, req_read_pos);
            good_total     += want.sentence_ok;
            format_total   += want.format_error;
            checksum_total += want.checksum_error;
            awaited_results.push_back(want);
         end
      end
      failures       <= fail_total;
      outstanding    <= awaited_results.size();
      good_count     <= good_total;
      format_count   <= format_total;
      checksum_count <= checksum_total;
   end

endmodule

FILE: sim/nmea_sentence_parser_tb.sv
// Testbench top for the NMEA sentence parser: clock, reset, sentence stimulus and verdict.
module nmea_sentence_parser_tb;
   import nmea_pkg::*;

   localparam int ITEM_TARGET = 800;
   localparam int QUIET_TAIL  = 150;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic       req_mode;
   logic [7:0] req_rx_char;
   logic [4:0] req_read_field;
   logic [3:0] req_read_pos;
   logic       rsp_valid;
   logic       rsp_ready;
   logic       rsp_sentence_ok;
   logic       rsp_format_error;
   logic       rsp_checksum_error;
   logic [5:0] rsp_field_count;
   logic [7:0] rsp_read_char;

   int failures;
   int outstanding;
   int good_count;
   int format_count;
   int checksum_count;

   bit          idling_on = 1'b1;
   int unsigned request_count;

   nmea_sentence_parser dut (.*);

   nmea_sentence_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #8000000;
      $display("end of test: mismatches");
      $finish;
   end

   // The response side stalls in bursts while idling is allowed.
   initial begin
      rsp_ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (idling_on && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   task automatic send_request(input logic       mode,
                               input logic [7:0] ch,
                               input logic [4:0] fld,
                               input logic [3:0] pos);
      if (idling_on && $urandom_range(0, 9) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_mode       <= mode;
      req_rx_char    <= ch;
      req_read_field <= fld;
      req_read_pos   <= pos;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic read_slot(input logic [4:0] fld, input logic [3:0] pos);
      send_request(1'b1, 8'($urandom), fld, pos);
      request_count++;
   endtask

   // Most reads land on the low slots, where sentences actually leave data.
   task automatic read_random_slot();
      if ($urandom_range(0, 9) < 7) begin
         read_slot(5'($urandom_range(0, 7)), 4'($urandom_range(0, 7)));
      end else begin
         read_slot(5'($urandom), 4'($urandom));
      end
   endtask

   task automatic put_byte(input logic [7:0] c);
      if ($urandom_range(0, 9) == 0) begin
         read_random_slot();
      end
      send_request(1'b0, c, 5'($urandom), 4'($urandom));
      request_count++;
   endtask

   // Pauses the sender until the parser has answered every request.
   task automatic drain_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] body_char();
      logic [7:0] c;
      do begin
         if ($urandom_range(0, 9) == 0) begin
            c = 8'($urandom);
         end else begin
            c = 8'($urandom_range(8'h20, 8'h7E));
         end
      end while (c == CH_COMMA || c == CH_STAR);
      return c;
   endfunction

   function automatic logic [7:0] digit_char(input int unsigned v, input bit lower);
      if (v < 10) begin
         return 8'("0" + v);
      end
      return lower ? 8'("a" + v - 10) : 8'("A" + v - 10);
   endfunction

   task automatic send_sentence(input int nfields, input int minlen, input int maxlen,
                                input bit spoil);
      logic [7:0]  sum;
      logic [7:0]  c;
      logic [7:0]  hi_c;
      logic [7:0]  lo_c;
      int unsigned hi;
      int unsigned lo;
      int          len;
      sum = 8'h00;
      put_byte(CH_DOLLAR);
      for (int f = 0; f < nfields; f++) begin
         if (f > 0) begin
            put_byte(CH_COMMA);
            sum ^= CH_COMMA;
         end
         len = $urandom_range(minlen, maxlen);
         for (int k = 0; k < len; k++) begin
            c = body_char();
            put_byte(c);
            sum ^= c;
         end
      end
      put_byte(CH_STAR);
      hi = sum[7:4];
      lo = sum[3:0];
      // Letters past F still count, so a borrow from the high digit keeps the sum.
      if (hi > 0 && $urandom_range(0, 9) == 0) begin
         hi = hi - 1;
         lo = lo + 16;
      end
      hi_c = digit_char(hi, $urandom_range(0, 1));
      lo_c = digit_char(lo, $urandom_range(0, 1));
      if (spoil) begin
         if ($urandom_range(0, 1) == 0) begin
            hi_c = 8'($urandom);
         end else begin
            lo_c = 8'($urandom);
         end
      end
      put_byte(hi_c);
      put_byte(lo_c);
   endtask

   task automatic send_garbage();
      int n;
      n = $urandom_range(1, 20);
      repeat (n) begin
         case ($urandom_range(0, 5))
            0:       put_byte(CH_DOLLAR);
            1:       put_byte(CH_COMMA);
            2:       put_byte(CH_STAR);
            default: put_byte(8'($urandom));
         endcase
      end
   endtask

   initial begin
      int pick;
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_mode       <= 1'b0;
      req_rx_char    <= 8'h00;
      req_read_field <= 5'd0;
      req_read_pos   <= 4'd0;
      request_count   = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Extreme bytes while hunting are ignored.
      put_byte(8'h00);
      put_byte(8'hFF);
      // A short good sentence with one field, then its stored field read back.
      put_byte(CH_DOLLAR);
      put_byte("A");
      put_byte(CH_STAR);
      put_byte("4");
      put_byte("1");
      read_slot(5'd0, 4'd0);
      read_slot(5'd0, 4'd1);
      read_slot(5'd31, 4'd15);
      // A lower-case letter beyond F as the low digit still gives a match.
      put_byte(CH_DOLLAR);
      put_byte(" ");
      put_byte(CH_STAR);
      put_byte("1");
      put_byte("g");
      // A dollar inside the body is data, and as a check digit it counts nought.
      put_byte(CH_DOLLAR);
      put_byte(CH_DOLLAR);
      put_byte(CH_STAR);
      put_byte(CH_DOLLAR);
      put_byte("4");
      // A decoded checksum above 255 can never match.
      put_byte(CH_DOLLAR);
      put_byte(CH_COMMA);
      put_byte(CH_STAR);
      put_byte("z");
      put_byte("z");
      drain_responses();

      while (request_count < ITEM_TARGET) begin
         if (request_count >= ITEM_TARGET - QUIET_TAIL) begin
            idling_on = 1'b0;
         end
         pick = $urandom_range(0, 99);
         if (pick < 50) begin
            send_sentence($urandom_range(1, 6), 0, 8, $urandom_range(0, 4) == 0);
         end else if (pick < 58) begin
            send_sentence($urandom_range(1, 3), 13, 16, 1'b0);
         end else if (pick < 65) begin
            send_sentence($urandom_range(29, 36), 0, 1, $urandom_range(0, 4) == 0);
         end else if (pick < 80) begin
            repeat ($urandom_range(1, 4)) read_random_slot();
         end else if (pick < 92) begin
            send_garbage();
         end else begin
            // Line noise between sentences; the parser mostly just skips it.
            repeat ($urandom_range(1, 6)) begin
               send_request(1'b0, 8'($urandom), 5'($urandom), 4'($urandom));
               request_count++;
            end
         end
         if ($urandom_range(0, 59) == 0) begin
            drain_responses();
         end
      end

      drain_responses();
      repeat (20) @(posedge clock);
      $display("Covered %0d requests: %0d good sentences, %0d checksum rejections,",
               request_count, good_count, checksum_count);
      $display("%0d format aborts and field reads throughout.", format_count);
      if (failures == 0 && outstanding == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
